/* rtl/core/i8tmm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i8tmm_pkg
// Shared types, sizes and helpers for the tiled int8 matrix multiplier.
// ----------------------------------------------------------------------------
package i8tmm_pkg;

  // Matrix geometry
  localparam int MATRIX_DIM = 24;
  localparam int TILE_COLS  = 6;
  localparam int DOT_LENGTH = 24;
  localparam int LANES      = 8;
  localparam int CHUNKS     = (DOT_LENGTH + LANES - 1) / LANES;
  localparam int NUM_GROUPS = MATRIX_DIM / TILE_COLS;

  // Field widths
  localparam int ELEM_W  = 8;
  localparam int IDX_W   = 5;
  localparam int CHUNK_W = 2;
  localparam int SUM_W   = 20;
  localparam int ROW_W   = 5;
  localparam int GROUP_W = 2;
  localparam int SLOT_W  = $clog2(TILE_COLS);
  localparam int PROD_W  = 2 * ELEM_W;

  // A buffer: one word per chunk of a row
  localparam int A_DEPTH = MATRIX_DIM * CHUNKS;
  localparam int ADDR_W  = $clog2(A_DEPTH);

  // Stream packing
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_CHUNK_LSB = IN_IDX_LSB + IDX_W;
  localparam int IN_LANE_LSB  = IN_CHUNK_LSB + CHUNK_W;
  localparam int IN_BITS      = IN_LANE_LSB + LANES * ELEM_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_ROW_LSB  = TILE_COLS * SUM_W;
  localparam int OUT_GRP_LSB  = OUT_ROW_LSB + ROW_W;
  localparam int OUT_BITS     = OUT_GRP_LSB + GROUP_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Item kinds carried in tuser
  typedef enum logic {
    KIND_A_ROW = 1'b0,
    KIND_B_COL = 1'b1
  } kind_t;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [LANES-1:0]        chunk_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Position of a B column inside its tile
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [SLOT_W-1:0]  slot;
  } tile_pos_t;

  // Per-cycle control broadcast to every column lane
  typedef struct packed {
    logic               advance;    // pipeline moves this cycle
    logic [CHUNK_W-1:0] b_wchunk;   // chunk slot of an incoming B beat
    logic [CHUNK_W-1:0] rd_chunk;   // chunk of the A word now on the read port
    logic               acc_en;     // a partial sum reaches the accumulator
    logic               acc_first;  // that partial sum starts a new row
  } lane_ctl_t;

  // Split a column index into tile group and slot by a short compare chain.
  function automatic tile_pos_t tile_split(input logic [IDX_W-1:0] idx);
    tile_pos_t pos;
    pos.group = '0;
    pos.slot  = SLOT_W'(idx);
    for (int g = 1; g < NUM_GROUPS; g++) begin
      if (idx >= IDX_W'(g * TILE_COLS)) begin
        pos.group = GROUP_W'(g);
        pos.slot  = SLOT_W'(idx - IDX_W'(g * TILE_COLS));
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/i8tmm_abuf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i8tmm_abuf
// Storage for matrix A, one eight-byte chunk per word, with a registered read.
// ----------------------------------------------------------------------------
module i8tmm_abuf
  import i8tmm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire chunk_t            wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output chunk_t                 rdata
);

  chunk_t mem [A_DEPTH];

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/i8tmm_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i8tmm_lane
// One column lane: holds one B column of the tile and accumulates its dot
// product with the passing A row, eight elements per cycle while ctl.advance.
// ----------------------------------------------------------------------------
module i8tmm_lane
  import i8tmm_pkg::*;
(
  input  wire logic      clk,
  input  wire lane_ctl_t ctl,
  input  wire logic      b_we,
  input  wire chunk_t    b_wdata,
  input  wire chunk_t    a_chunk,
  output sum_t           acc
);

  chunk_t                    bcol [CHUNKS];
  logic signed [PROD_W-1:0]  prod [LANES];
  sum_t                      part;
  sum_t                      part_next;
  chunk_t                    b_rd;

  // Column storage, written one chunk per beat.
  always_ff @(posedge clk) begin
    if (b_we) begin
      bcol[ctl.b_wchunk] <= b_wdata;
    end
  end

  assign b_rd = bcol[ctl.rd_chunk];

  // Element products, registered.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      for (int i = 0; i < LANES; i++) begin
        prod[i] <= $signed(a_chunk[i]) * $signed(b_rd[i]);
      end
    end
  end

  // Sum of the products of one chunk.
  always_comb begin
    part_next = '0;
    for (int i = 0; i < LANES; i++) begin
      part_next = part_next + SUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      part <= part_next;
    end
  end

  // Row accumulator across the chunks of a row.
  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.acc_en) begin
      acc <= ctl.acc_first ? part : acc + part;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/int8_tiled_matrix_multiply.sv */
`timescale 1ns / 1ps
`default_nettype none
// A beat that completes a tile's last column starts a run: each A chunk passes the A
//   buffer read, product, partial sum and row accumulator registers, and each row goes
//   out through the output register. The input stays closed for the run (24 rows x 3
//   chunks of A reads plus the pipeline drain); A and B beats otherwise go back to back.
// Reset: rst (synchronous) clears control and handshake state; matrix storage is
//   not cleared and must be written before it is used.
// ----------------------------------------------------------------------------
// int8_tiled_matrix_multiply
// Stores A rows and a tile of six B columns, then streams every A row past six
// column lanes and emits one six-wide row of exact dot products per A row.
// ----------------------------------------------------------------------------
module int8_tiled_matrix_multiply
  import i8tmm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // vec_index[4:0], chunk[6:5], lane0[14:7] .. lane7[70:63], zero pad[71]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // kind[0]
  input  wire logic                   s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // sum0[19:0] .. sum5[119:100], out_row[124:120], col_group[126:125], zero pad[127]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast
);

  // Input beat decode
  logic [IDX_W-1:0]   in_idx;
  logic [CHUNK_W-1:0] in_chunk;
  chunk_t             in_lanes;
  kind_t              in_kind;
  tile_pos_t          in_pos;
  logic               in_acc;
  logic               in_ok;
  logic               trigger;

  assign in_idx   = s_tdata[IN_IDX_LSB +: IDX_W];
  assign in_chunk = s_tdata[IN_CHUNK_LSB +: CHUNK_W];
  assign in_lanes = s_tdata[IN_LANE_LSB +: LANES * ELEM_W];
  assign in_kind  = kind_t'(s_tuser);
  assign in_pos   = tile_split(in_idx);
  assign in_acc   = s_tvalid && s_tready;
  assign in_ok    = (in_idx < IDX_W'(MATRIX_DIM)) && (in_chunk < CHUNK_W'(CHUNKS));
  assign trigger  = in_acc && in_ok && (in_kind == KIND_B_COL)
                    && (in_chunk == CHUNK_W'(CHUNKS - 1))
                    && (in_pos.slot == SLOT_W'(TILE_COLS - 1));

  // Control state
  logic               busy;
  logic               issuing;
  logic [ROW_W-1:0]   row_cnt;
  logic [CHUNK_W-1:0] chk_cnt;
  logic [ADDR_W-1:0]  rd_addr;
  logic [GROUP_W-1:0] group;
  logic               advance;

  // Pipeline tags
  logic               v1, v2, v3, v4;
  logic [CHUNK_W-1:0] ch1, ch2, ch3;
  logic [ROW_W-1:0]   row1, row2, row3, row4;

  // Output register
  sum_t               out_sum [TILE_COLS];
  logic [ROW_W-1:0]   out_row;
  logic [GROUP_W-1:0] out_group;
  logic               out_last;

  logic               final_row;

  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !busy;
  assign final_row = v4 && (row4 == ROW_W'(MATRIX_DIM - 1));

  // Row and chunk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      issuing <= 1'b0;
      row_cnt <= '0;
      chk_cnt <= '0;
      rd_addr <= '0;
    end else if (trigger) begin
      busy    <= 1'b1;
      issuing <= 1'b1;
      row_cnt <= '0;
      chk_cnt <= '0;
      rd_addr <= '0;
    end else if (advance) begin
      if (issuing) begin
        rd_addr <= rd_addr + ADDR_W'(1);
        if (chk_cnt == CHUNK_W'(CHUNKS - 1)) begin
          chk_cnt <= '0;
          row_cnt <= row_cnt + ROW_W'(1);
          if (row_cnt == ROW_W'(MATRIX_DIM - 1)) begin
            issuing <= 1'b0;
          end
        end else begin
          chk_cnt <= chk_cnt + CHUNK_W'(1);
        end
      end
      if (final_row) begin
        busy <= 1'b0;
      end
    end
  end

  // Tile group of the run, taken from the triggering column.
  always_ff @(posedge clk) begin
    if (trigger) begin
      group <= in_pos.group;
    end
  end

  // Valid bits travel with the data through read, product, partial and accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && (ch3 == CHUNK_W'(CHUNKS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ch1  <= chk_cnt;
      ch2  <= ch1;
      ch3  <= ch2;
      row1 <= row_cnt;
      row2 <= row1;
      row3 <= row2;
      row4 <= row3;
    end
  end

  // A buffer
  chunk_t             a_rdata;
  logic [ADDR_W-1:0]  a_waddr;
  logic               a_we;

  assign a_we    = in_acc && in_ok && (in_kind == KIND_A_ROW);
  assign a_waddr = ADDR_W'(ADDR_W'(in_idx) * ADDR_W'(CHUNKS) + ADDR_W'(in_chunk));

  i8tmm_abuf u_abuf (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_lanes),
    .re    (advance && issuing),
    .raddr (rd_addr),
    .rdata (a_rdata)
  );

  // Column lanes
  lane_ctl_t lane_ctl;
  sum_t      lane_acc [TILE_COLS];

  assign lane_ctl.advance   = advance;
  assign lane_ctl.b_wchunk  = in_chunk;
  assign lane_ctl.rd_chunk  = ch1;
  assign lane_ctl.acc_en    = v3;
  assign lane_ctl.acc_first = (ch3 == '0);

  for (genvar c = 0; c < TILE_COLS; c++) begin : g_lane
    logic b_we;

    assign b_we = in_acc && in_ok && (in_kind == KIND_B_COL)
                  && (in_pos.slot == SLOT_W'(c));

    i8tmm_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .b_we    (b_we),
      .b_wdata (in_lanes),
      .a_chunk (a_rdata),
      .acc     (lane_acc[c])
    );
  end

  // Merge stage: capture the six lane sums of a finished row.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v4) begin
      for (int c = 0; c < TILE_COLS; c++) begin
        out_sum[c] <= lane_acc[c];
      end
      out_row   <= row4;
      out_group <= group;
      out_last  <= (row4 == ROW_W'(MATRIX_DIM - 1));
    end
  end

  // Output beat packing
  always_comb begin
    m_tdata = '0;
    for (int c = 0; c < TILE_COLS; c++) begin
      m_tdata[c * SUM_W +: SUM_W] = out_sum[c];
    end
    m_tdata[OUT_ROW_LSB +: ROW_W]   = out_row;
    m_tdata[OUT_GRP_LSB +: GROUP_W] = out_group;
  end

  assign m_tlast = out_last;

  // Checks
  a_issue_in_run: assert property (@(posedge clk) disable iff (rst)
    issuing |-> busy)
    else $error("row issue active outside a run");

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(v1 || v2 || v3 || v4))
    else $error("pipeline holds data while idle");

  // A waiting final row means the previous run has fully drained the pipeline.
  a_last_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !(v1 || v2 || v3 || v4))
    else $error("final row shown while the pipeline still holds data");

  a_trigger_idle: assert property (@(posedge clk) disable iff (rst)
    trigger |=> busy && issuing)
    else $error("tile trigger did not start a run");

endmodule
`default_nettype wire
